@@ hdl/rjseg_pkg.sv @@
// Shared types and constants for the range-jump object segmenter.
// Field widths, register indexes and the fixed-point angle reduction constants.
// No dependencies.
`default_nettype none

package rjseg_pkg;

    localparam int RANGE_W    = 16;
    localparam int INTEN_W    = 16;
    localparam int INDEX_W    = 12;
    localparam int COUNT_W    = 6;
    localparam int ANGLE_W    = 16;
    localparam int STEP_W     = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int PROD_W      = INDEX_W + STEP_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int LOW_W       = 4;
    localparam int DIV_W       = SUM_W - LOW_W;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 35;
    localparam int QUOT_W      = 12;
    localparam int QPROD_W     = DIV_W + RECIP_W;
    localparam int REM_W       = 13;
    localparam int FOLD_W      = QUOT_W + 12;

    // two pi is 51472 = 16 * 3217; divide by 3217 through a reciprocal
    localparam logic [RECIP_W-1:0] RECIP      = 24'd10680677;
    localparam logic [11:0]        DIVISOR    = 12'd3217;
    localparam logic [ANGLE_W-1:0] ANG_WRAP   = 16'd7032;
    localparam logic [ANGLE_W-1:0] ANG_POS    = 16'd18704;
    localparam logic [ANGLE_W-1:0] ANG_NEG    = 16'd32768;
    localparam logic signed [ANGLE_W-1:0] ANG_MIN = -16'sd25735;
    localparam logic signed [ANGLE_W-1:0] ANG_MAX = 16'sd25736;

    localparam logic [RANGE_W-1:0] RANGE_FAR = '1;

    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OBJECTS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP     = 3'd5;

    typedef struct packed {
        logic [INTEN_W-1:0]        intensity_min;
        logic [RANGE_W-1:0]        jump_threshold;
        logic [RANGE_W-1:0]        range_limit;
        logic [COUNT_W-1:0]        max_objects;
        logic signed [ANGLE_W-1:0] angle_start;
        logic [STEP_W-1:0]         angle_step;
    } cfg_t;

    typedef struct packed {
        logic                      valid;
        logic [RANGE_W-1:0]        range;
        logic [INDEX_W-1:0]        index;
        logic signed [ANGLE_W-1:0] start;
        logic [STEP_W-1:0]         step;
        logic [COUNT_W-1:0]        number;
    } obj_t;

endpackage

`default_nettype wire

@@ hdl/rjseg_track.sv @@
// Segment tracker: scan state and the open/close decision for each request.
// Registers a closed object (nearest range, its sample index and angle settings, its number).
// Depends on rjseg_pkg.
`default_nettype none

module rjseg_track (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire rjseg_pkg::cfg_t         cfg,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [rjseg_pkg::RANGE_W-1:0] s_range_mm,
    input  wire [rjseg_pkg::INTEN_W-1:0] s_intensity,
    input  wire [rjseg_pkg::INDEX_W-1:0] s_sample_index,
    input  wire                          s_first_of_scan,
    output rjseg_pkg::obj_t              obj,
    input  wire                          obj_take
);
    import rjseg_pkg::*;

    logic [RANGE_W-1:0] prev_reg, prev_next;
    logic               inside_reg, inside_next;
    logic [RANGE_W-1:0] near_reg, near_next;
    logic [INDEX_W-1:0] near_idx_reg, near_idx_next;
    logic signed [ANGLE_W-1:0] near_start_reg, near_start_next;
    logic [STEP_W-1:0]  near_step_reg, near_step_next;
    logic [COUNT_W-1:0] found_reg, found_next;
    obj_t               obj_reg, obj_next;

    logic               accept;
    logic [RANGE_W-1:0] cur_prev;
    logic               cur_inside;
    logic [RANGE_W-1:0] cur_near;
    logic [COUNT_W-1:0] cur_found;
    logic [RANGE_W-1:0] upd_near;
    logic [INDEX_W-1:0] upd_idx;
    logic signed [ANGLE_W-1:0] upd_start;
    logic [STEP_W-1:0]  upd_step;
    logic               close_hit;
    logic               open_hit;

    assign s_ready = !obj_reg.valid || obj_take;
    assign accept  = s_valid && s_ready;
    assign obj     = obj_reg;

    always_comb begin
        cur_prev   = s_first_of_scan ? '0 : prev_reg;
        cur_inside = s_first_of_scan ? 1'b0 : inside_reg;
        cur_near   = s_first_of_scan ? RANGE_FAR : near_reg;
        cur_found  = s_first_of_scan ? '0 : found_reg;

        upd_near  = (s_range_mm < cur_near) ? s_range_mm : cur_near;
        upd_idx   = (s_range_mm < cur_near) ? s_sample_index : near_idx_reg;
        upd_start = (s_range_mm < cur_near) ? cfg.angle_start : near_start_reg;
        upd_step  = (s_range_mm < cur_near) ? cfg.angle_step : near_step_reg;

        close_hit = {1'b0, s_range_mm} > ({1'b0, cur_prev} + {1'b0, cfg.jump_threshold});
        open_hit  = (({1'b0, s_range_mm} + {1'b0, cfg.jump_threshold}) < {1'b0, cur_prev})
                    && (s_range_mm < cfg.range_limit);

        prev_next       = cur_prev;
        inside_next     = cur_inside;
        near_next       = cur_near;
        near_idx_next   = near_idx_reg;
        near_start_next = near_start_reg;
        near_step_next  = near_step_reg;
        found_next      = cur_found;

        obj_next        = obj_reg;
        obj_next.valid  = 1'b0;
        obj_next.range  = upd_near;
        obj_next.index  = upd_idx;
        obj_next.start  = upd_start;
        obj_next.step   = upd_step;
        obj_next.number = cur_found;

        if (s_intensity >= cfg.intensity_min) begin
            prev_next = s_range_mm;
            if (cur_inside) begin
                near_next       = upd_near;
                near_idx_next   = upd_idx;
                near_start_next = upd_start;
                near_step_next  = upd_step;
                if (close_hit) begin
                    inside_next = 1'b0;
                    near_next   = RANGE_FAR;
                    if ((cur_found < cfg.max_objects) && (upd_near < cfg.range_limit)) begin
                        obj_next.valid = accept;
                        found_next     = cur_found + 1'b1;
                    end
                end
            end else if (open_hit) begin
                inside_next     = 1'b1;
                near_next       = s_range_mm;
                near_idx_next   = s_sample_index;
                near_start_next = cfg.angle_start;
                near_step_next  = cfg.angle_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg       <= '0;
            inside_reg     <= 1'b0;
            near_reg       <= RANGE_FAR;
            near_idx_reg   <= '0;
            near_start_reg <= '0;
            near_step_reg  <= '0;
            found_reg      <= '0;
            obj_reg        <= '0;
        end else begin
            if (accept) begin
                prev_reg       <= prev_next;
                inside_reg     <= inside_next;
                near_reg       <= near_next;
                near_idx_reg   <= near_idx_next;
                near_start_reg <= near_start_next;
                near_step_reg  <= near_step_next;
                found_reg      <= found_next;
            end
            if (s_ready) begin
                obj_reg <= obj_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/rjseg_angle.sv @@
// Angle pipeline: sample index times step, offset, reduction into (-pi, pi].
// Ends in the result register that drives the m_ channel. Depends on rjseg_pkg.
`default_nettype none

module rjseg_angle (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire rjseg_pkg::obj_t         obj,
    output logic                         obj_take,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [rjseg_pkg::RANGE_W-1:0] m_object_range,
    output logic signed [rjseg_pkg::ANGLE_W-1:0] m_object_angle,
    output logic [rjseg_pkg::COUNT_W-1:0] m_object_number
);
    import rjseg_pkg::*;

    logic               s2_valid_reg;
    logic [PROD_W-1:0]  s2_prod_reg, s2_prod_next;
    logic signed [ANGLE_W-1:0] s2_start_reg;
    logic [RANGE_W-1:0] s2_range_reg;
    logic [COUNT_W-1:0] s2_number_reg;

    logic               s3_valid_reg;
    logic [DIV_W-1:0]   s3_div_reg, s3_div_next;
    logic [LOW_W-1:0]   s3_low_reg, s3_low_next;
    logic [QUOT_W-1:0]  s3_quot_reg, s3_quot_next;
    logic [RANGE_W-1:0] s3_range_reg;
    logic [COUNT_W-1:0] s3_number_reg;

    logic               out_valid_reg;
    logic [RANGE_W-1:0] out_range_reg;
    logic [ANGLE_W-1:0] out_angle_reg, out_angle_next;
    logic [COUNT_W-1:0] out_number_reg;

    logic go_out, go3, go2;

    logic [SUM_W-1:0]   sum;
    logic [QPROD_W-1:0] qprod;
    logic [FOLD_W-1:0]  fold;
    logic [FOLD_W-1:0]  rem_wide;
    logic [REM_W-1:0]   rem_a, rem_b;
    logic [ANGLE_W-1:0] rem_full;

    assign go_out   = !out_valid_reg || m_ready;
    assign go3      = !s3_valid_reg || go_out;
    assign go2      = !s2_valid_reg || go3;
    assign obj_take = go2;

    assign s2_prod_next = PROD_W'(obj.index) * PROD_W'(obj.step);

    always_comb begin
        sum = {1'b0, s2_prod_reg}
              + SUM_W'({~s2_start_reg[ANGLE_W-1], s2_start_reg[ANGLE_W-2:0]});
        s3_div_next  = sum[SUM_W-1:LOW_W];
        s3_low_next  = sum[LOW_W-1:0];
        qprod        = QPROD_W'(s3_div_next) * QPROD_W'(RECIP);
        s3_quot_next = qprod[RECIP_SHIFT +: QUOT_W];
    end

    always_comb begin
        fold     = FOLD_W'(s3_quot_reg) * FOLD_W'(DIVISOR);
        rem_wide = FOLD_W'(s3_div_reg) - fold;
        rem_a    = rem_wide[REM_W-1:0];
        rem_b    = (rem_a >= REM_W'(DIVISOR)) ? rem_a - REM_W'(DIVISOR) : rem_a;
        rem_full = {rem_b[REM_W-2:0], s3_low_reg};
        out_angle_next = (rem_full <= ANG_WRAP) ? rem_full + ANG_POS : rem_full - ANG_NEG;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (go2) begin
                s2_valid_reg <= obj.valid;
            end
            if (go3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (go_out) begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go2) begin
            s2_prod_reg   <= s2_prod_next;
            s2_start_reg  <= obj.start;
            s2_range_reg  <= obj.range;
            s2_number_reg <= obj.number;
        end
        if (go3) begin
            s3_div_reg    <= s3_div_next;
            s3_low_reg    <= s3_low_next;
            s3_quot_reg   <= s3_quot_next;
            s3_range_reg  <= s2_range_reg;
            s3_number_reg <= s2_number_reg;
        end
        if (go_out) begin
            out_range_reg  <= s3_range_reg;
            out_angle_reg  <= out_angle_next;
            out_number_reg <= s3_number_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_object_range  = out_range_reg;
    assign m_object_angle  = out_angle_reg;
    assign m_object_number = out_number_reg;

endmodule

`default_nettype wire

@@ hdl/range_jump_object_segmenter_unit.sv @@
// Top level of the range-jump object segmenter: configuration registers,
// segment tracker and angle pipeline. Depends on rjseg_pkg, rjseg_track, rjseg_angle.
//
// Usage:
//   s_ channel: one scan sample per request (range, intensity, index, first flag).
//   m_ channel: one request per reported object (nearest range, angle, number).
//   cfg port:   cfg_wr_en writes cfg_wdata into register cfg_index;
//               write only while no sample is in flight.
//   Throughput: one sample per cycle while s_ready is high; the scan state is updated
//   at the edge that accepts the sample, so the next sample follows with no gap.
//   Result path: a closing sample's result passes through the tracker register,
//   product register, quotient register and result register in that order;
//   the multiply and modulo 2*pi reduction set the depth.
//   Reset: synchronous on aresetn low; configuration registers return to their defaults,
//   scan state cleared, pipeline emptied.
//   Stall: m_ready held low fills the three stages behind the result register,
//   after which s_ready drops; no request is lost or repeated.
`default_nettype none

module range_jump_object_segmenter_unit (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire [rjseg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [rjseg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire [rjseg_pkg::RANGE_W-1:0]      s_range_mm,
    input  wire [rjseg_pkg::INTEN_W-1:0]      s_intensity,
    input  wire [rjseg_pkg::INDEX_W-1:0]      s_sample_index,
    input  wire                               s_first_of_scan,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [rjseg_pkg::RANGE_W-1:0]     m_object_range,
    output logic signed [rjseg_pkg::ANGLE_W-1:0] m_object_angle,
    output logic [rjseg_pkg::COUNT_W-1:0]     m_object_number
);
    import rjseg_pkg::*;

    cfg_t cfg_reg;
    obj_t obj;
    logic obj_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.intensity_min  <= 16'd0;
            cfg_reg.jump_threshold <= 16'd100;
            cfg_reg.range_limit    <= 16'd3000;
            cfg_reg.max_objects    <= 6'd10;
            cfg_reg.angle_start    <= 16'sd0;
            cfg_reg.angle_step     <= 14'd36;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_INTENSITY_MIN:  cfg_reg.intensity_min  <= cfg_wdata;
                REG_JUMP_THRESHOLD: cfg_reg.jump_threshold <= cfg_wdata;
                REG_RANGE_LIMIT:    cfg_reg.range_limit    <= cfg_wdata;
                REG_MAX_OBJECTS:    cfg_reg.max_objects    <= cfg_wdata[COUNT_W-1:0];
                REG_ANGLE_START:    cfg_reg.angle_start    <= cfg_wdata;
                REG_ANGLE_STEP:     cfg_reg.angle_step     <= cfg_wdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rjseg_track u_track (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_range_mm      (s_range_mm),
        .s_intensity     (s_intensity),
        .s_sample_index  (s_sample_index),
        .s_first_of_scan (s_first_of_scan),
        .obj             (obj),
        .obj_take        (obj_take)
    );

    rjseg_angle u_angle (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .obj             (obj),
        .obj_take        (obj_take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_object_range  (m_object_range),
        .m_object_angle  (m_object_angle),
        .m_object_number (m_object_number)
    );

`ifndef SYNTH
    a_angle_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_object_angle >= ANG_MIN) && (m_object_angle <= ANG_MAX))
        else $error("object angle outside (-pi, pi]");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a stalled result");
`endif

endmodule

`default_nettype wire
